[rtl/core/ale_pkg.sv]
// ----------------------------------------------------------------------------
// ale_pkg
// Shared types and codes for the array list engine: command and result
// beats, command and status codes, store control group, default depth.
// ----------------------------------------------------------------------------
`default_nettype none

package ale_pkg;

	// default number of list entries
	localparam int DEF_LIST_DEPTH = 16;

	// command codes
	localparam logic [1:0] CMD_INSERT    = 2'd0;
	localparam logic [1:0] CMD_DELETE    = 2'd1;
	localparam logic [1:0] CMD_FIND_NEXT = 2'd2;
	localparam logic [1:0] CMD_FIND_PREV = 2'd3;

	// status codes
	localparam logic [1:0] ST_OK           = 2'd0;
	localparam logic [1:0] ST_BAD_POS      = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND    = 2'd2;
	localparam logic [1:0] ST_NO_NEIGHBOUR = 2'd3;

	// command beat
	typedef struct packed {
		logic [1:0]         command;
		logic [4:0]         position;
		logic signed [31:0] operand_value;
	} cmd_beat_t;

	// result beat
	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] neighbour_value;
		logic [4:0]         list_length;
	} rsp_beat_t;

	// store access enables from the sequencer
	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} store_ctl_t;

endpackage : ale_pkg

`default_nettype wire

[rtl/core/ale_store.sv]
// ----------------------------------------------------------------------------
// ale_store
// Entry store of the list: one write port and one read port with
// registered read data. Contents are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module ale_store #(
	parameter int LIST_DEPTH = ale_pkg::DEF_LIST_DEPTH,
	localparam int AW = $clog2(LIST_DEPTH)
) (
	input  wire                   clk,
	input  ale_pkg::store_ctl_t   ctl,
	input  wire [AW-1:0]          rd_addr,
	input  wire [AW-1:0]          wr_addr,
	input  wire [31:0]            wr_data,
	output logic [31:0]           rd_data
);
	import ale_pkg::*;

	logic [31:0] mem_q [LIST_DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule : ale_store

`default_nettype wire

[rtl/core/array_list_engine.sv]
// Sequence from the command beat to a valid result beat: insert and delete
// move entries by a read state and a write state per entry moved, a find
// reads and compares one entry per pass, and a refused command goes straight
// to the result state; the store has one read port and one write port.
// Commands: one at a time, the next taken in the cycle after the result
// is loaded. Reset: count cleared, store left undefined, no clearing pass.
// ----------------------------------------------------------------------------
// array_list_engine
// Bounded ordered list of signed words with insert, delete and neighbour
// search, run by a small sequencer over one store and one index counter.
// ----------------------------------------------------------------------------
`default_nettype none

module array_list_engine #(
	parameter int LIST_DEPTH = ale_pkg::DEF_LIST_DEPTH
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cmd_valid,
	output logic                cmd_stall,
	input  ale_pkg::cmd_beat_t  cmd,
	output logic                rsp_valid,
	input  wire                 rsp_stall,
	output ale_pkg::rsp_beat_t  rsp
);
	import ale_pkg::*;

	localparam int AW   = $clog2(LIST_DEPTH);
	localparam int CW   = $clog2(LIST_DEPTH + 1);
	localparam int CMPW = (CW > 5) ? CW : 5;

	typedef enum logic [6:0] {
		S_IDLE     = 7'b0000001,
		S_SHIFT_RD = 7'b0000010,
		S_SHIFT_WR = 7'b0000100,
		S_SCAN_RD  = 7'b0001000,
		S_SCAN_CHK = 7'b0010000,
		S_NB_TAKE  = 7'b0100000,
		S_RESP     = 7'b1000000
	} state_t;

	state_t             state_q, state_d;
	logic [CW-1:0]      count_q, count_d;
	logic [CW-1:0]      idx_q, idx_d;
	logic [CW-1:0]      pos_q, pos_d;
	logic               is_ins_q, is_ins_d;
	logic               is_next_q, is_next_d;
	logic [31:0]        val_q, val_d;
	logic [1:0]         status_q, status_d;
	logic [31:0]        nb_q, nb_d;

	store_ctl_t         st_ctl;
	logic [CW-1:0]      rd_idx, wr_idx;
	logic [AW-1:0]      rd_addr, wr_addr;
	logic [31:0]        wr_data, rd_data;

	logic               accept;
	logic               rsp_free;
	logic [CMPW-1:0]    pos_w, cnt_w;
	logic [CW-1:0]      idx_inc;

	assign accept    = cmd_valid && !cmd_stall;
	assign cmd_stall = (state_q != S_IDLE);
	assign rsp_free  = !rsp_valid || !rsp_stall;
	assign pos_w     = CMPW'(cmd.position);
	assign cnt_w     = CMPW'(count_q);
	assign idx_inc   = idx_q + CW'(1);
	assign rd_addr   = rd_idx[AW-1:0];
	assign wr_addr   = wr_idx[AW-1:0];

	// sequencer
	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		idx_d     = idx_q;
		pos_d     = pos_q;
		is_ins_d  = is_ins_q;
		is_next_d = is_next_q;
		val_d     = val_q;
		status_d  = status_q;
		nb_d      = nb_q;
		st_ctl    = '0;
		rd_idx    = idx_q;
		wr_idx    = idx_q;
		wr_data   = rd_data;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					val_d     = cmd.operand_value;
					pos_d     = CW'(cmd.position);
					is_ins_d  = (cmd.command == CMD_INSERT);
					is_next_d = (cmd.command == CMD_FIND_NEXT);
					status_d  = ST_OK;
					nb_d      = '0;
					case (cmd.command)
						CMD_INSERT: begin
							if ((count_q >= CW'(LIST_DEPTH)) || (pos_w > cnt_w)) begin
								status_d = ST_BAD_POS;
								state_d  = S_RESP;
							end else begin
								idx_d   = count_q;
								state_d = S_SHIFT_RD;
							end
						end
						CMD_DELETE: begin
							if ((cmd.position == 5'd0) || (pos_w > cnt_w)) begin
								status_d = ST_BAD_POS;
								state_d  = S_RESP;
							end else begin
								idx_d   = CW'(cmd.position);
								state_d = S_SHIFT_RD;
							end
						end
						default: begin
							idx_d   = '0;
							state_d = S_SCAN_RD;
						end
					endcase
				end
			end
			// read the entry to move, or finish the shift
			S_SHIFT_RD: begin
				if (is_ins_q) begin
					if (idx_q > pos_q) begin
						rd_idx       = idx_q - CW'(1);
						st_ctl.rd_en = 1'b1;
						state_d      = S_SHIFT_WR;
					end else begin
						wr_idx       = pos_q;
						wr_data      = val_q;
						st_ctl.wr_en = 1'b1;
						count_d      = count_q + CW'(1);
						state_d      = S_RESP;
					end
				end else begin
					if (idx_q < count_q) begin
						rd_idx       = idx_q;
						st_ctl.rd_en = 1'b1;
						state_d      = S_SHIFT_WR;
					end else begin
						count_d = count_q - CW'(1);
						state_d = S_RESP;
					end
				end
			end
			// write the moved entry one place up or down
			S_SHIFT_WR: begin
				st_ctl.wr_en = 1'b1;
				if (is_ins_q) begin
					wr_idx = idx_q;
					idx_d  = idx_q - CW'(1);
				end else begin
					wr_idx = idx_q - CW'(1);
					idx_d  = idx_inc;
				end
				state_d = S_SHIFT_RD;
			end
			// read the next entry to compare, or report not found at the end
			S_SCAN_RD: begin
				if (idx_q < count_q) begin
					st_ctl.rd_en = 1'b1;
					state_d      = S_SCAN_CHK;
				end else begin
					status_d = ST_NOT_FOUND;
					state_d  = S_RESP;
				end
			end
			// compare, and on a hit fetch the neighbour
			S_SCAN_CHK: begin
				if (rd_data == val_q) begin
					if (is_next_q) begin
						if (idx_inc >= count_q) begin
							status_d = ST_NO_NEIGHBOUR;
							state_d  = S_RESP;
						end else begin
							rd_idx       = idx_inc;
							st_ctl.rd_en = 1'b1;
							state_d      = S_NB_TAKE;
						end
					end else begin
						if (idx_q == '0) begin
							status_d = ST_NO_NEIGHBOUR;
							state_d  = S_RESP;
						end else begin
							rd_idx       = idx_q - CW'(1);
							st_ctl.rd_en = 1'b1;
							state_d      = S_NB_TAKE;
						end
					end
				end else begin
					idx_d   = idx_inc;
					state_d = S_SCAN_RD;
				end
			end
			S_NB_TAKE: begin
				nb_d    = rd_data;
				state_d = S_RESP;
			end
			// hand the result to the output register
			S_RESP: begin
				if (rsp_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		idx_q     <= idx_d;
		pos_q     <= pos_d;
		is_ins_q  <= is_ins_d;
		is_next_q <= is_next_d;
		val_q     <= val_d;
		status_q  <= status_d;
		nb_q      <= nb_d;
	end

	// result beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if ((state_q == S_RESP) && rsp_free) begin
			rsp_valid <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_RESP) && rsp_free) begin
			rsp.status          <= status_q;
			rsp.neighbour_value <= nb_q;
			rsp.list_length     <= 5'(count_q);
		end
	end

	// entry store
	ale_store #(
		.LIST_DEPTH (LIST_DEPTH)
	) u_store (
		.clk     (clk),
		.ctl     (st_ctl),
		.rd_addr (rd_addr),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_data (rd_data)
	);

endmodule : array_list_engine

`default_nettype wire
